// File: rtl/assert_macros.svh
// Assertion macros shared by the top, divider cell and output stage RTL files of the divide, modulo and shift unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property checked outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never be seen outside reset.
`define ASSERT_NEVER_AT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER_AT(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/cdms_pkg.sv
// Package with types, codes and helpers of the checked divide, modulo and shift unit.
package cdms_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SHIFT_W    = $clog2(DATA_WIDTH);

    localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH'(DATA_WIDTH);
    localparam logic [DATA_WIDTH-1:0] MOST_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES  = {DATA_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        OP_DIV = 2'd0,
        OP_MOD = 2'd1,
        OP_SHL = 2'd2,
        OP_SAR = 2'd3
    } cdms_op_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_SHIFT    = 2'd3
    } cdms_err_t;

    // Request payload.
    typedef struct packed {
        logic [1:0]                   func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } cdms_req_t;

    // Response payload.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic [1:0]                   error_code;
    } cdms_rsp_t;

    // Work carried from cell to cell along the divider chain.
    typedef struct packed {
        logic [1:0]            func;
        logic [1:0]            err;
        logic                  div_en;
        logic                  neg_q;
        logic                  neg_r;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] qa;
        logic [DATA_WIDTH-1:0] dvs;
    } cdms_stage_t;

    // Two's complement negation within the data width.
    function automatic logic [DATA_WIDTH-1:0] neg_w(input logic [DATA_WIDTH-1:0] v);
        return (~v) + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    endfunction

endpackage

// File: rtl/checked_divide_modulo_shift_unit_top.sv
// A request passes the input stage, one divider cell per quotient bit and the
// response register.
// Throughput: one request per cycle while rsp_ready does not stall the response;
// the DATA_WIDTH restoring cells hold one request each and pass it on unless stalled.
// Reset clears only the valid flags of the stages; no request is in flight after reset.
// Top level of the checked divide, modulo and shift unit.
`include "assert_macros.svh"

module checked_divide_modulo_shift_unit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  cdms_pkg::cdms_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cdms_pkg::cdms_rsp_t rsp_data
);

    cdms_pkg::cdms_stage_t           stage_data  [0:cdms_pkg::DATA_WIDTH];
    logic [cdms_pkg::DATA_WIDTH:0]   stage_valid;
    logic [cdms_pkg::DATA_WIDTH:0]   stage_ready;

    // Input stage.
    cdms_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req_data),
        .dn_valid (stage_valid[0]),
        .dn_ready (stage_ready[0]),
        .dn_data  (stage_data[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar k = 0; k < cdms_pkg::DATA_WIDTH; k++)
    begin : g_cell
        cdms_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[k]),
            .up_ready (stage_ready[k]),
            .up_data  (stage_data[k]),
            .dn_valid (stage_valid[k+1]),
            .dn_ready (stage_ready[k+1]),
            .dn_data  (stage_data[k+1])
        );
    end

    // Output stage.
    cdms_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[cdms_pkg::DATA_WIDTH]),
        .up_ready (stage_ready[cdms_pkg::DATA_WIDTH]),
        .up_data  (stage_data[cdms_pkg::DATA_WIDTH]),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn_data  (rsp_data)
    );

    // With the response register empty, the whole chain can move and take a request.
    `ASSERT_AT(a_ready_when_out_empty, clk, rst_n, !rsp_valid |-> req_ready)

endmodule

// File: rtl/cdms_prep.sv
// Input stage: error checks, operand magnitudes and the shift datapath.
module cdms_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  cdms_pkg::cdms_req_t   up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output cdms_pkg::cdms_stage_t dn_data
);

    logic                            valid_reg;
    cdms_pkg::cdms_stage_t           data_reg;
    cdms_pkg::cdms_stage_t           data_next;
    logic [cdms_pkg::DATA_WIDTH-1:0] ua;
    logic [cdms_pkg::DATA_WIDTH-1:0] ub;
    logic signed [cdms_pkg::DATA_WIDTH-1:0] sa;
    logic [cdms_pkg::SHIFT_W-1:0]    sh;
    logic                            is_div;
    logic                            shift_bad;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Decode the request and classify errors.
    always_comb
    begin
        ua        = up_data.operand_a;
        ub        = up_data.operand_b;
        sa        = up_data.operand_a;
        sh        = ub[cdms_pkg::SHIFT_W-1:0];
        is_div    = (up_data.func == cdms_pkg::OP_DIV) || (up_data.func == cdms_pkg::OP_MOD);
        shift_bad = (ub >= cdms_pkg::WIDTH_VAL);

        data_next.func  = up_data.func;
        data_next.neg_q = ua[cdms_pkg::DATA_WIDTH-1] ^ ub[cdms_pkg::DATA_WIDTH-1];
        data_next.neg_r = ua[cdms_pkg::DATA_WIDTH-1];
        data_next.rem   = '0;
        data_next.dvs   = ub[cdms_pkg::DATA_WIDTH-1] ? cdms_pkg::neg_w(ub) : ub;

        // A zero divisor is checked before the overflow case.
        if (is_div)
        begin
            if (ub == '0)
            begin
                data_next.err = cdms_pkg::ERR_DIV_ZERO;
            end
            else if ((ua == cdms_pkg::MOST_NEG) && (ub == cdms_pkg::ALL_ONES))
            begin
                data_next.err = cdms_pkg::ERR_OVERFLOW;
            end
            else
            begin
                data_next.err = cdms_pkg::ERR_OK;
            end
        end
        else
        begin
            data_next.err = shift_bad ? cdms_pkg::ERR_SHIFT : cdms_pkg::ERR_OK;
        end

        data_next.div_en = is_div && (data_next.err == cdms_pkg::ERR_OK);

        // The quotient slot carries the dividend magnitude or the shifted value.
        unique case (up_data.func)
            cdms_pkg::OP_DIV,
            cdms_pkg::OP_MOD: data_next.qa = ua[cdms_pkg::DATA_WIDTH-1] ?
                                             cdms_pkg::neg_w(ua) : ua;
            cdms_pkg::OP_SHL: data_next.qa = ua << sh;
            cdms_pkg::OP_SAR: data_next.qa = sa >>> sh;
            default:          data_next.qa = ua;
        endcase
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/cdms_cell.sv
// One divider cell: a single restoring step that yields one quotient bit.
`include "assert_macros.svh"

module cdms_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  cdms_pkg::cdms_stage_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output cdms_pkg::cdms_stage_t dn_data
);

    logic                          valid_reg;
    cdms_pkg::cdms_stage_t         data_reg;
    cdms_pkg::cdms_stage_t         data_next;
    logic [cdms_pkg::DATA_WIDTH:0] trial;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        data_next = up_data;
        trial     = {up_data.rem, up_data.qa[cdms_pkg::DATA_WIDTH-1]} -
                    {1'b0, up_data.dvs};
        if (up_data.div_en)
        begin
            if (!trial[cdms_pkg::DATA_WIDTH])
            begin
                data_next.rem = trial[cdms_pkg::DATA_WIDTH-1:0];
                data_next.qa  = {up_data.qa[cdms_pkg::DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = {up_data.rem[cdms_pkg::DATA_WIDTH-2:0],
                                 up_data.qa[cdms_pkg::DATA_WIDTH-1]};
                data_next.qa  = {up_data.qa[cdms_pkg::DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Cell register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    // The partial remainder of an active division stays below the divisor.
    `ASSERT_AT(a_rem_below_dvs, clk, rst_n, (valid_reg && data_reg.div_en) |-> (data_reg.rem < data_reg.dvs))

endmodule

// File: rtl/cdms_post.sv
// Output stage: sign correction, error masking and the response register.
`include "assert_macros.svh"

module cdms_post (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  cdms_pkg::cdms_stage_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output cdms_pkg::cdms_rsp_t   dn_data
);

    logic                            valid_reg;
    cdms_pkg::cdms_rsp_t             rsp_reg;
    cdms_pkg::cdms_rsp_t             rsp_next;
    logic [cdms_pkg::DATA_WIDTH-1:0] res;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = rsp_reg;

    // Apply the result signs; any error forces a zero result.
    always_comb
    begin
        unique case (up_data.func)
            cdms_pkg::OP_DIV: res = up_data.neg_q ? cdms_pkg::neg_w(up_data.qa) : up_data.qa;
            cdms_pkg::OP_MOD: res = up_data.neg_r ? cdms_pkg::neg_w(up_data.rem) : up_data.rem;
            cdms_pkg::OP_SHL,
            cdms_pkg::OP_SAR: res = up_data.qa;
            default:          res = up_data.qa;
        endcase
        rsp_next.error_code   = up_data.err;
        rsp_next.result_value = (up_data.err == cdms_pkg::ERR_OK) ? res : '0;
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // A flagged error always comes with a zero result.
    `ASSERT_AT(a_err_zero_result, clk, rst_n, (valid_reg && (rsp_reg.error_code != cdms_pkg::ERR_OK)) |-> (rsp_reg.result_value == '0))
    // An error entering the stage reaches the response register unchanged.
    `ASSERT_AT(a_err_carried, clk, rst_n, (up_valid && up_ready) |=> (rsp_reg.error_code == $past(up_data.err)))

endmodule
